FILE: sv/indexed_insert_delete_list_macros.svh
// Assertion helpers used by the list top level.
`ifndef INDEXED_INSERT_DELETE_LIST_MACROS_SVH
`define INDEXED_INSERT_DELETE_LIST_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define IIDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define IIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/iidl_pkg.sv
package iidl_pkg;

  // Request codes
  typedef enum logic [2:0] {
    MODE_READ        = 3'd0,
    MODE_INSERT      = 3'd1,
    MODE_REMOVE      = 3'd2,
    MODE_APPEND      = 3'd3,
    MODE_REMOVE_LAST = 3'd4,
    MODE_CLEAR       = 3'd5
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned OutCntW = 5;

  // Broadcast control for the cell row
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] value;
  } cell_ctl_t;

endpackage

FILE: sv/iidl_cell.sv
module iidl_cell #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic                              clk_i,
  input  iidl_pkg::cell_ctl_t               ctl_i,
  input  logic [IdxW-1:0]                   tgt_i,
  input  logic signed [iidl_pkg::ValueW-1:0] left_i,
  input  logic signed [iidl_pkg::ValueW-1:0] right_i,
  output logic signed [iidl_pkg::ValueW-1:0] entry_o,
  output logic signed [iidl_pkg::ValueW-1:0] rd_o
);
  import iidl_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic signed [ValueW-1:0] entry_d, entry_q;
  logic                     above, at;

  assign above = MyIdx > tgt_i;
  assign at    = MyIdx == tgt_i;

  // Shift up on insert, shift down on remove, otherwise hold
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && above) begin
      entry_d = left_i;
    end else if (ctl_i.ins && at) begin
      entry_d = ctl_i.value;
    end else if (ctl_i.rem && (above || at)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Drive the read bus only when addressed
  assign rd_o    = at ? entry_q : '0;
  assign entry_o = entry_q;

endmodule

FILE: sv/indexed_insert_delete_list.sv
// Channel   Dir  Fields (low bit up)                          Beats
// s_axis    in   mode[2:0] position[6:3] item_value[38:7]     one per request
// m_axis    out  value_out[31:0] entry_count[36:32]           one per request
//                status[38:37]
//
// One request per cycle unless m_axis stalls: cells at and above the target shift in
// the accepting cycle and the result is registered for the next cycle.
// Input is taken whenever the result register is empty or drained in the same cycle.
// A stalled m_axis holds one result and stops s_axis until it is taken.
// Reset clears the entry count and the result valid flag; entries are not cleared.
`include "indexed_insert_delete_list_macros.svh"

module indexed_insert_delete_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[2:0], position[6:3], item_value[38:7], zero pad[39]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // value_out[31:0], entry_count[36:32], status[38:37], zero pad[39]
  output logic [39:0] m_axis_tdata
);
  import iidl_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned ExtW = (CntW > OutCntW) ? CntW : OutCntW;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic                     in_acc;
  mode_e                    mode;
  logic [PosW-1:0]          pos;
  logic signed [ValueW-1:0] item_value;
  logic [CmpW-1:0]          pos_w, cnt_w;
  logic [CntW-1:0]          count_d, count_q;
  logic                     full;
  logic [IdxW-1:0]          tgt;
  cell_ctl_t                ctl;
  logic signed [ValueW-1:0] rd_val, res_val;
  status_e                  res_st;
  logic [ExtW-1:0]          cnt_ext;

  logic                     m_valid_q;
  logic signed [ValueW-1:0] m_value_q;
  logic [OutCntW-1:0]       m_count_q;
  status_e                  m_status_q;

  logic signed [ValueW-1:0] ent [CAPACITY];
  logic signed [ValueW-1:0] rd  [CAPACITY];

  // Unpack the request beat
  assign mode       = mode_e'(s_axis_tdata[2:0]);
  assign pos        = s_axis_tdata[6:3];
  assign item_value = s_axis_tdata[38:7];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign pos_w = CmpW'(pos);
  assign cnt_w = CmpW'(count_q);
  assign full  = count_q == CapCnt;

  // Pick the addressed cell
  always_comb begin
    case (mode)
      MODE_APPEND:      tgt = count_q[IdxW-1:0];
      MODE_REMOVE_LAST: tgt = IdxW'(count_q - CntW'(1));
      default:          tgt = pos_w[IdxW-1:0];
    endcase
  end

  // Decode the request against the current count
  always_comb begin
    ctl       = '0;
    ctl.value = item_value;
    count_d   = count_q;
    res_val   = '0;
    res_st    = ST_OK;
    case (mode)
      MODE_READ: begin
        if (pos_w < cnt_w) res_val = rd_val;
        else               res_st  = ST_RANGE;
      end
      MODE_INSERT: begin
        if (full) begin
          res_st = ST_FULL;
        end else if (pos_w > cnt_w) begin
          res_st = ST_RANGE;
        end else begin
          ctl.ins = in_acc;
          count_d = count_q + CntW'(1);
        end
      end
      MODE_REMOVE: begin
        if (pos_w < cnt_w) begin
          ctl.rem = in_acc;
          res_val = rd_val;
          count_d = count_q - CntW'(1);
        end else begin
          res_st = ST_RANGE;
        end
      end
      MODE_APPEND: begin
        if (full) begin
          res_st = ST_FULL;
        end else begin
          ctl.ins = in_acc;
          count_d = count_q + CntW'(1);
        end
      end
      MODE_REMOVE_LAST: begin
        if (count_q == '0) begin
          res_st = ST_RANGE;
        end else begin
          ctl.rem = in_acc;
          res_val = rd_val;
          count_d = count_q - CntW'(1);
        end
      end
      MODE_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  // Row of storage cells, each fed by its neighbors (zero below the first, the last by itself)
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = ent[i];
    end else begin : g_mid_r
      assign right_w = ent[i+1];
    end
    iidl_cell #(
      .IdxW(IdxW),
      .Idx (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .tgt_i  (tgt),
      .left_i (left_w),
      .right_i(right_w),
      .entry_o(ent[i]),
      .rd_o   (rd[i])
    );
  end

  // Merge the one-hot read bus
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | rd[i];
    end
  end

  assign cnt_ext = ExtW'(count_d);

  // Hold count and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_value_q  <= res_val;
      m_count_q  <= cnt_ext[OutCntW-1:0];
      m_status_q <= res_st;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_status_q, m_count_q, m_value_q};

  `IIDL_ASSERT(a_count_bound, count_q <= CapCnt, "entry count above capacity")
  `IIDL_ASSERT_NEXT(a_ins_count, ctl.ins, count_q == $past(count_q) + CntW'(1), "count not grown")
  `IIDL_ASSERT(a_full_status, !m_valid_q || m_status_q != ST_FULL || full, "full status with room")

endmodule
